>>> rtl/matrix_keypad_scanner_assert.svh
// Assertion macros for the keypad scanner; kps_back uses them.
`ifndef MATRIX_KEYPAD_SCANNER_ASSERT_SVH
`define MATRIX_KEYPAD_SCANNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad scanner assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad scanner assertion failed");

`endif

>>> rtl/kps_pkg.sv
`default_nettype none

package kps_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int MAX_LINES  = 16;
    localparam int LINE_W     = 16;
    localparam int CODE_W     = 5;
    localparam int KEY_W      = 8;
    localparam int TICK_W     = 8;
    localparam int FILL_W     = 5;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    // Configuration register indexes.
    localparam logic [1:0] CFG_COLUMN_COUNT   = 2'd0;
    localparam logic [1:0] CFG_ROW_COUNT      = 2'd1;
    localparam logic [1:0] CFG_DEBOUNCE_TICKS = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PRESSED,
        PH_HELD
    } phase_t;

    typedef enum logic [1:0] {
        OP_SCAN,
        OP_KEY,
        OP_POP
    } op_t;

    typedef struct packed {
        logic [CODE_W-1:0] column_count;
        logic [CODE_W-1:0] row_count;
        logic [TICK_W-1:0] debounce_ticks;
    } cfg_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] code;
    } cmd_t;

    typedef struct packed {
        logic              key_event;
        logic [KEY_W-1:0]  key_code;
        logic              key_stored;
        logic              read_valid;
        logic [KEY_W-1:0]  read_value;
        logic [FILL_W-1:0] queued_count;
    } result_t;

    // Highest active line among the first count lines, plus one; zero if none.
    function automatic logic [CODE_W-1:0] encode_lines(input logic [LINE_W-1:0] lines,
                                                       input logic [CODE_W-1:0] count);
        logic [CODE_W-1:0] code;
        code = '0;
        for (int i = 0; i < MAX_LINES; i++) begin
            if (lines[i] && (CODE_W'(i) < count)) begin
                code = CODE_W'(i + 1);
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

>>> rtl/matrix_keypad_scanner.sv
// Matrix keypad scanner with column debounce and a 16-entry key queue.
// Input channel: an item (kind, column_lines, row_lines) transfers when push is
// high and full is low. Kind 0 is a scan tick, kind 1 asks to pop one key.
// Result channel: while empty is low the oldest result is on the result ports,
// and it transfers when pop is high. Every input item gives exactly one result.
// Configuration channel: cfg_index selects column_count (0), row_count (1) or
// debounce_ticks (2); the low bits of cfg_data are written when cfg_valid is
// high, since cfg_ready is always high. Other indexes are ignored.
// An input item is written into the command queue, and its result then into the
// output buffer, before empty goes low. The block takes one item per cycle while
// full is low; the scan front end, the two-entry command queue and the key queue
// back end each take one item in a cycle while the stage after them has room.
// Reset clears the debounce state and phase, empties the key queue and loads
// column_count 4, row_count 4 and debounce_ticks 3.
// When the receiver stalls, results collect in a two-entry output buffer, then
// commands collect in the two-entry command queue, and then full rises until
// pop frees space. No input item or result is dropped.
`default_nettype none

module matrix_keypad_scanner
    import kps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              kind,
    input  wire logic [LINE_W-1:0] column_lines,
    input  wire logic [LINE_W-1:0] row_lines,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [7:0]        cfg_data,
    output logic                   empty,
    input  wire logic              pop,
    output logic                   key_event,
    output logic [KEY_W-1:0]       key_code,
    output logic                   key_stored,
    output logic                   read_valid,
    output logic [KEY_W-1:0]       read_value,
    output logic [FILL_W-1:0]      queued_count
);

    cfg_t    cfg_reg;
    logic    in_fire;
    logic    q_in_ready;
    cmd_t    front_cmd;
    logic    q_out_valid;
    logic    q_out_ready;
    cmd_t    q_out_cmd;
    logic    res_valid;
    result_t res;

    // Configuration registers; writes must arrive only while the block is idle, but the block does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.column_count   <= CODE_W'(4);
            cfg_reg.row_count      <= CODE_W'(4);
            cfg_reg.debounce_ticks <= TICK_W'(3);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_COLUMN_COUNT:   cfg_reg.column_count   <= cfg_data[CODE_W-1:0];
                CFG_ROW_COUNT:      cfg_reg.row_count      <= cfg_data[CODE_W-1:0];
                CFG_DEBOUNCE_TICKS: cfg_reg.debounce_ticks <= cfg_data[TICK_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // The front end updates its scan state on every scan-tick transfer and hands a
    // classified command to the queue in the same cycle.
    assign full    = !q_in_ready;
    assign in_fire = push && !full;

    kps_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_fire),
        .kind         (kind),
        .column_lines (column_lines),
        .row_lines    (row_lines),
        .cfg          (cfg_reg),
        .cmd          (front_cmd)
    );

    kps_cmd_queue u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_fire),
        .in_ready  (q_in_ready),
        .in_cmd    (front_cmd),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_cmd   (q_out_cmd)
    );

    // The back end owns the key queue and the result buffer.
    kps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_out_valid),
        .cmd_ready (q_out_ready),
        .cmd       (q_out_cmd),
        .res_valid (res_valid),
        .res_ready (pop),
        .res       (res)
    );

    assign empty        = !res_valid;
    assign key_event    = res.key_event;
    assign key_code     = res.key_code;
    assign key_stored   = res.key_stored;
    assign read_valid   = res.read_valid;
    assign read_value   = res.read_value;
    assign queued_count = res.queued_count;

endmodule

`default_nettype wire

>>> rtl/kps_front.sv
`default_nettype none

module kps_front
    import kps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              kind,
    input  wire logic [LINE_W-1:0] column_lines,
    input  wire logic [LINE_W-1:0] row_lines,
    input  wire cfg_t              cfg,
    output cmd_t                   cmd
);

    logic [CODE_W-1:0] stable_level_reg, stable_level_next;
    logic [TICK_W-1:0] debounce_count_reg, debounce_count_next;
    phase_t            phase_reg, phase_next;
    logic [CODE_W-1:0] latched_column_reg, latched_column_next;
    logic [CODE_W-1:0] latched_row_reg, latched_row_next;

    logic [CODE_W-1:0] col_code;
    logic [TICK_W-1:0] count_inc;
    logic [KEY_W-1:0]  row_minus_one;
    logic [KEY_W-1:0]  product;

    assign col_code      = encode_lines(column_lines, cfg.column_count);
    assign count_inc     = debounce_count_reg + TICK_W'(1);
    assign row_minus_one = KEY_W'({3'b000, latched_row_reg}) - KEY_W'(1);
    assign product       = row_minus_one * KEY_W'({3'b000, cfg.column_count});

    always_comb begin
        stable_level_next   = stable_level_reg;
        debounce_count_next = debounce_count_reg;
        phase_next          = phase_reg;
        latched_column_next = latched_column_reg;
        latched_row_next    = latched_row_reg;
        cmd.op              = OP_SCAN;
        cmd.code            = '0;

        if (kind) begin
            cmd.op = OP_POP;
        end else begin
            // Debounce first; the phase machine sees the updated level.
            if (col_code != stable_level_reg) begin
                if (count_inc >= cfg.debounce_ticks) begin
                    stable_level_next   = col_code;
                    debounce_count_next = '0;
                end else begin
                    debounce_count_next = count_inc;
                end
            end else begin
                debounce_count_next = '0;
            end

            case (phase_reg)
                PH_IDLE:
                begin
                    if (stable_level_next != '0) begin
                        latched_column_next = stable_level_next;
                        latched_row_next    = encode_lines(row_lines, cfg.row_count);
                        phase_next          = PH_PRESSED;
                    end
                end
                PH_PRESSED:
                begin
                    if (stable_level_next != '0) begin
                        phase_next = PH_HELD;
                    end
                end
                PH_HELD:
                begin
                    if (stable_level_next == '0) begin
                        cmd.op     = OP_KEY;
                        cmd.code   = KEY_W'({3'b000, latched_column_reg}) + product;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
        end else if (accept) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            stable_level_reg   <= '0;
            debounce_count_reg <= '0;
            latched_column_reg <= '0;
            latched_row_reg    <= '0;
        end else if (accept) begin
            stable_level_reg   <= stable_level_next;
            debounce_count_reg <= debounce_count_next;
            latched_column_reg <= latched_column_next;
            latched_row_reg    <= latched_row_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/kps_cmd_queue.sv
`default_nettype none

module kps_cmd_queue
    import kps_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire cmd_t in_cmd,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      out_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_write, do_read;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign do_write  = in_valid && in_ready;
    assign do_read   = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (do_write && !do_read) begin
            count_next = count_reg + 2'd1;
        end else if (!do_write && do_read) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_write) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_read) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (do_write) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/kps_back.sv
`default_nettype none

`include "matrix_keypad_scanner_assert.svh"

module kps_back
    import kps_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    output logic      res_valid,
    input  wire logic res_ready,
    output result_t   res
);

    logic [KEY_W-1:0]  key_store_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  write_pointer_reg, write_pointer_next;
    logic [PTR_W-1:0]  read_pointer_reg, read_pointer_next;
    logic [FILL_W-1:0] fill_count_reg, fill_count_next;
    logic [PTR_W-1:0]  write_inc, read_inc;
    logic              store_en;
    result_t           res_new;

    result_t    res_buf_reg [2];
    logic       res_wr_reg, res_rd_reg;
    logic [1:0] res_count_reg, res_count_next;
    logic       cmd_take, res_take;

    assign cmd_ready = (res_count_reg != 2'd2);
    assign cmd_take  = cmd_valid && cmd_ready;
    assign res_valid = (res_count_reg != 2'd0);
    assign res_take  = res_valid && res_ready;
    assign res       = res_buf_reg[res_rd_reg];

    assign write_inc = (write_pointer_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                       : write_pointer_reg + PTR_W'(1);
    assign read_inc  = (read_pointer_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                       : read_pointer_reg + PTR_W'(1);

    always_comb begin
        write_pointer_next = write_pointer_reg;
        read_pointer_next  = read_pointer_reg;
        fill_count_next    = fill_count_reg;
        store_en           = 1'b0;
        res_new            = '0;

        case (cmd.op)
            OP_KEY:
            begin
                res_new.key_event = 1'b1;
                res_new.key_code  = cmd.code;
                if (fill_count_reg != FILL_W'(FIFO_DEPTH)) begin
                    res_new.key_stored = 1'b1;
                    store_en           = 1'b1;
                    write_pointer_next = write_inc;
                    fill_count_next    = fill_count_reg + FILL_W'(1);
                end
            end
            OP_POP:
            begin
                if (fill_count_reg != '0) begin
                    res_new.read_valid = 1'b1;
                    res_new.read_value = key_store_reg[read_inc];
                    read_pointer_next  = read_inc;
                    fill_count_next    = fill_count_reg - FILL_W'(1);
                end
            end
            default:
            begin
                store_en = 1'b0;
            end
        endcase
        res_new.queued_count = fill_count_next;
    end

    always_comb begin
        res_count_next = res_count_reg;
        if (cmd_take && !res_take) begin
            res_count_next = res_count_reg + 2'd1;
        end else if (!cmd_take && res_take) begin
            res_count_next = res_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            write_pointer_reg <= '0;
            read_pointer_reg  <= '0;
            fill_count_reg    <= '0;
            res_wr_reg        <= 1'b0;
            res_rd_reg        <= 1'b0;
            res_count_reg     <= '0;
        end else begin
            res_count_reg <= res_count_next;
            if (cmd_take) begin
                write_pointer_reg <= write_pointer_next;
                read_pointer_reg  <= read_pointer_next;
                fill_count_reg    <= fill_count_next;
                res_wr_reg        <= !res_wr_reg;
            end
            if (res_take) begin
                res_rd_reg <= !res_rd_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd_take && store_en) begin
            key_store_reg[write_inc] <= cmd.code;
        end
        if (cmd_take) begin
            res_buf_reg[res_wr_reg] <= res_new;
        end
    end

    `KPS_ASSERT_SAME(a_fill_bound, clk, rst_n, 1'b1, fill_count_reg <= FILL_W'(FIFO_DEPTH))
    `KPS_ASSERT_SAME(a_stored_needs_event, clk, rst_n, res_valid && res.key_stored, res.key_event)
    `KPS_ASSERT_NEXT(a_pop_drains, clk, rst_n,
                     cmd_take && cmd.op == OP_POP && fill_count_reg != '0,
                     fill_count_reg == $past(fill_count_reg) - FILL_W'(1))
    `KPS_ASSERT_NEXT(a_full_drops, clk, rst_n,
                     cmd_take && cmd.op == OP_KEY && fill_count_reg == FILL_W'(FIFO_DEPTH),
                     $stable(write_pointer_reg))

endmodule

`default_nettype wire
